### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check an implication that must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

### rtl/mts_pkg.sv
package mts_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int TIME_WIDTH = 32;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int MASK_W     = 16;
    localparam int PER_IN_W   = 31;
    localparam logic [63:0] PERIOD_MAX = (64'd1 << (TIME_WIDTH - 1)) - 64'd1;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_STOP  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_ACCEPTED  = 2'd0,
        KIND_REJECTED  = 2'd1,
        KIND_EXPIRED   = 2'd2,
        KIND_NO_EXPIRY = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_REARM,
        ST_SCAN,
        ST_START_FIN,
        ST_STOP_FIN,
        ST_TCHECK
    } t_state;

    typedef struct packed {
        logic  load;
        logic  arm_start;
        logic  remove_slot;
        logic  time_inc;
        logic  sel_cur;
        logic  load_mine;
        logic  pos_inc;
        logic  insert;
        logic  pop;
        logic  end_tick;
        logic  emit;
        t_kind emit_kind;
        logic  emit_pend;
        logic  pend_last;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic p_zero;
        logic idx_armed;
        logic scan_done;
        logic exp_hit;
        logic head_repeat;
        logic pend_valid;
    } t_dp_stat;

    // Ticks until a deadline; a deadline behind now counts as zero.
    function automatic logic [TIME_WIDTH-1:0] ticks_left(
        input logic [TIME_WIDTH-1:0] dl,
        input logic [TIME_WIDTH-1:0] now
    );
        logic [TIME_WIDTH-1:0] r;
        r = dl - now;
        return r[TIME_WIDTH-1] ? '0 : r;
    endfunction

endpackage

### rtl/mts_ctrl.sv
module mts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  mts_pkg::t_dp_stat i_stat,
    output mts_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import mts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (i_stat.req)
                    REQ_START: begin
                        if (i_stat.p_zero || i_stat.idx_armed) n_state = ST_IDLE;
                        else n_state = ST_REARM;
                    end
                    REQ_STOP: begin
                        n_state = i_stat.idx_armed ? ST_STOP_FIN : ST_IDLE;
                    end
                    REQ_TICK: n_state = ST_TCHECK;
                    REQ_NONE: n_state = ST_IDLE;
                endcase
            end
            ST_REARM: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = (i_stat.req == REQ_TICK) ? ST_TCHECK : ST_START_FIN;
                end
            end
            ST_START_FIN: n_state = ST_IDLE;
            ST_STOP_FIN:  n_state = ST_IDLE;
            ST_TCHECK: begin
                if (i_stat.exp_hit) n_state = i_stat.head_repeat ? ST_REARM : ST_TCHECK;
                else n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd = '0;
        o_cmd.emit_kind = KIND_ACCEPTED;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
            end
            ST_DISPATCH: begin
                unique case (i_stat.req)
                    REQ_START: begin
                        if (i_stat.p_zero) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = KIND_REJECTED;
                        end else if (i_stat.idx_armed) begin
                            o_cmd.emit = 1'b1;
                        end else begin
                            o_cmd.arm_start = 1'b1;
                        end
                    end
                    REQ_STOP: begin
                        if (i_stat.idx_armed) o_cmd.remove_slot = 1'b1;
                        else o_cmd.emit = 1'b1;
                    end
                    REQ_TICK: o_cmd.time_inc = 1'b1;
                    REQ_NONE: o_cmd.emit = 1'b0;
                endcase
            end
            ST_REARM: begin
                o_cmd.sel_cur   = 1'b1;
                o_cmd.load_mine = 1'b1;
            end
            ST_SCAN: begin
                if (i_stat.scan_done) o_cmd.insert = 1'b1;
                else o_cmd.pos_inc = 1'b1;
            end
            ST_START_FIN, ST_STOP_FIN: begin
                o_cmd.emit = 1'b1;
            end
            ST_TCHECK: begin
                o_cmd.emit_pend = i_stat.pend_valid;
                o_cmd.pend_last = !i_stat.exp_hit;
                if (i_stat.exp_hit) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.end_tick = 1'b1;
                    if (!i_stat.pend_valid) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_kind = KIND_NO_EXPIRY;
                    end
                end
            end
            default: o_cmd.emit = 1'b0;
        endcase
    end

endmodule

### rtl/mts_dp.sv
module mts_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mts_pkg::t_dp_cmd               i_cmd,
    output mts_pkg::t_dp_stat              o_stat,
    input  logic [1:0]                     i_req_type,
    input  logic [mts_pkg::IDX_W-1:0]      i_timer_index,
    input  logic [mts_pkg::PER_IN_W-1:0]   i_period_ticks,
    input  logic [mts_pkg::MASK_W-1:0]     i_repeat_mask,
    output logic                           o_valid,
    output logic [1:0]                     o_result_kind,
    output logic [mts_pkg::IDX_W-1:0]      o_slot_index,
    output logic [mts_pkg::MASK_W-1:0]     o_active_mask,
    output logic                           o_is_last
);
    import mts_pkg::*;

    t_req                  r_req;
    logic [IDX_W-1:0]      r_idx;
    logic [TIME_WIDTH-1:0] r_pin;
    logic [TIME_WIDTH-1:0] r_time;
    logic [TIME_WIDTH-1:0] r_deadline [SLOT_COUNT];
    logic [TIME_WIDTH-1:0] r_period   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_armed;
    logic [IDX_W-1:0]      r_order    [SLOT_COUNT];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_pos;
    logic [CNT_W-1:0]      r_n;
    logic [TIME_WIDTH-1:0] r_mine;
    logic [IDX_W-1:0]      r_cur;
    logic                  r_pend_v;
    logic [IDX_W-1:0]      r_pend_slot;
    logic [MASK_W-1:0]     r_pend_mask;
    logic                  r_out_valid;
    t_kind                 r_out_kind;
    logic [IDX_W-1:0]      r_out_slot;
    logic [MASK_W-1:0]     r_out_mask;
    logic                  r_out_last;

    logic [63:0]           p_wide;
    logic [TIME_WIDTH-1:0] p_sat;
    logic [IDX_W-1:0]      head;
    logic [IDX_W-1:0]      rd_addr;
    logic [TIME_WIDTH-1:0] rd_tl;
    logic [IDX_W-1:0]      find_pos;
    logic [IDX_W-1:0]      rm_pos;
    logic [SLOT_COUNT-1:0] head_bit;
    logic [SLOT_COUNT-1:0] pop_mask;

    assign p_wide  = 64'(i_period_ticks);
    assign p_sat   = (p_wide > PERIOD_MAX) ? PERIOD_MAX[TIME_WIDTH-1:0]
                                           : p_wide[TIME_WIDTH-1:0];
    assign head    = r_order[0];
    assign rd_addr = i_cmd.sel_cur ? r_cur : r_order[r_pos[IDX_W-1:0]];
    assign rd_tl   = ticks_left(r_deadline[rd_addr], r_time);
    assign head_bit = SLOT_COUNT'(1) << head;
    assign pop_mask = (r_armed & ~head_bit) |
                      (i_repeat_mask[head] ? head_bit : '0);

    // Locate the stopped slot among the armed list entries.
    always_comb begin
        find_pos = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if ((CNT_W'(i) < r_count) && (r_order[i] == r_idx)) find_pos |= IDX_W'(i);
        end
    end
    assign rm_pos = i_cmd.pop ? '0 : find_pos;

    assign o_stat.req         = r_req;
    assign o_stat.p_zero      = (r_pin == '0);
    assign o_stat.idx_armed   = r_armed[r_idx];
    assign o_stat.scan_done   = (r_pos == r_count) || (rd_tl > r_mine);
    assign o_stat.exp_hit     = (r_count != '0) && (r_n < CNT_W'(SLOT_COUNT))
                                && (rd_tl == '0);
    assign o_stat.head_repeat = i_repeat_mask[head];
    assign o_stat.pend_valid  = r_pend_v;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_armed     <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_n         <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit || i_cmd.emit_pend;
            if (i_cmd.load) begin
                r_pos    <= '0;
                r_n      <= '0;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.arm_start) r_armed[r_idx] <= 1'b1;
            if (i_cmd.time_inc) r_time <= r_time + TIME_WIDTH'(1);
            if (i_cmd.remove_slot) begin
                r_armed[r_idx] <= 1'b0;
                r_count        <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) r_time <= '0;
            end
            if (i_cmd.load_mine) r_pos <= '0;
            if (i_cmd.pos_inc) r_pos <= r_pos + CNT_W'(1);
            if (i_cmd.insert) begin
                r_pos   <= '0;
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.pop) begin
                r_armed[head] <= i_repeat_mask[head];
                r_count       <= r_count - CNT_W'(1);
                r_n           <= r_n + CNT_W'(1);
                r_pend_v      <= 1'b1;
            end else if (i_cmd.emit_pend) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.end_tick && (r_count == '0)) r_time <= '0;
        end
    end

    // Payload and timer tables.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= t_req'(i_req_type);
            r_idx <= i_timer_index;
            r_pin <= p_sat;
        end
        if (i_cmd.arm_start) begin
            r_period[r_idx]   <= r_pin;
            r_deadline[r_idx] <= r_time + r_pin;
            r_cur             <= r_idx;
        end
        if (i_cmd.load_mine) r_mine <= rd_tl;
        if (i_cmd.pop) begin
            r_cur       <= head;
            r_pend_slot <= head;
            r_pend_mask <= pop_mask[MASK_W-1:0];
            if (i_repeat_mask[head]) begin
                r_deadline[head] <= r_deadline[rd_addr] + r_period[rd_addr];
            end
        end
        if (i_cmd.insert) begin
            for (int i = 1; i < SLOT_COUNT; i++) begin
                if ((CNT_W'(i) > r_pos) && (CNT_W'(i) <= r_count)) begin
                    r_order[i] <= r_order[i-1];
                end
            end
            r_order[r_pos[IDX_W-1:0]] <= r_cur;
        end
        if (i_cmd.remove_slot || i_cmd.pop) begin
            for (int i = 0; i < SLOT_COUNT - 1; i++) begin
                if ((CNT_W'(i) >= CNT_W'(rm_pos)) && (CNT_W'(i + 1) < r_count)) begin
                    r_order[i] <= r_order[i+1];
                end
            end
        end
        if (i_cmd.emit_pend) begin
            r_out_kind <= KIND_EXPIRED;
            r_out_slot <= r_pend_slot;
            r_out_mask <= r_pend_mask;
            r_out_last <= i_cmd.pend_last;
        end else if (i_cmd.emit) begin
            r_out_kind <= i_cmd.emit_kind;
            r_out_slot <= (i_cmd.emit_kind == KIND_NO_EXPIRY) ? '0 : r_idx;
            r_out_mask <= r_armed[MASK_W-1:0];
            r_out_last <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_slot_index  = r_out_slot;
    assign o_active_mask = r_out_mask;
    assign o_is_last     = r_out_last;

endmodule

### rtl/multiplexed_timer_scheduler.sv
// Start ends at dispatch when rejected or already armed; else it re-arms, scans the
// list entries for its place and inserts. Stop ends at dispatch when the slot is not
// armed, else removes it and then reports. Tick checks the head, pops each expired slot
// and sends a repeating slot back through re-arm and a serial scan of the ordered list.
// Throughput: one request at a time; busy is high from accept until the last result.
// Reset (synchronous, active low) disarms all slots, clears time and repeat_mask.
module multiplexed_timer_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_req_type,
    input  logic [mts_pkg::IDX_W-1:0]      i_timer_index,
    input  logic [mts_pkg::PER_IN_W-1:0]   i_period_ticks,
    // result channel
    output logic                           o_valid,
    output logic [1:0]                     o_result_kind,
    output logic [mts_pkg::IDX_W-1:0]      o_slot_index,
    output logic [mts_pkg::MASK_W-1:0]     o_active_mask,
    output logic                           o_is_last,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mts_pkg::*;

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [MASK_W-1:0] r_repeat_mask;
    logic              accept;

    // Only repeat_mask lives at addresses 0 to 3 (paddr[2] low); addresses 4 to 7 read as zero.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_repeat_mask) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_mask <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_repeat_mask <= pwdata[MASK_W-1:0];
        end
    end

    // Take a request only while the sequencer is idle.
    assign accept = start && !busy;

    // Controller: walks each request through dispatch, list scan and result emit.
    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath: time base, slot tables, ordered list and result registers.
    mts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req_type),
        .i_timer_index  (i_timer_index),
        .i_period_ticks (i_period_ticks),
        .i_repeat_mask  (r_repeat_mask),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_slot_index   (o_slot_index),
        .o_active_mask  (o_active_mask),
        .o_is_last      (o_is_last)
    );

endmodule

### rtl/mts_checker.sv
`include "assert_macros.svh"

module mts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [1:0] o_result_kind,
    input logic [3:0] o_slot_index,
    input logic       o_is_last
);
    import mts_pkg::*;

    logic w_reject;
    logic w_noexp;
    logic w_noexp_ok;

    assign w_reject   = o_valid && (o_result_kind == KIND_REJECTED);
    assign w_noexp    = o_valid && (o_result_kind == KIND_NO_EXPIRY);
    assign w_noexp_ok = o_is_last && (o_slot_index == '0);

    `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
    `ASSERT_IMPL(a_last_idle, o_valid && o_is_last, !busy, "last result while still busy")
    `ASSERT_IMPL(a_more_busy, o_valid && !o_is_last, busy, "non-final result after idle")
    `ASSERT_IMPL(a_reject_last, w_reject, o_is_last, "reject not final")
    `ASSERT_IMPL(a_noexp_fmt, w_noexp, w_noexp_ok, "bad idle tick result")

endmodule

bind multiplexed_timer_scheduler mts_checker u_mts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_result_kind (o_result_kind),
    .o_slot_index  (o_slot_index),
    .o_is_last     (o_is_last)
);

### verif/multiplexed_timer_scheduler_tb.sv
`timescale 1ns / 1ps

module multiplexed_timer_scheduler_tb;
    import mts_pkg::*;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  slot;
        logic [15:0] mask;
        logic        last;
    } t_timer_event;

    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [3:0]  i_timer_index;
    logic [30:0] i_period_ticks;
    logic        o_valid;
    logic [1:0]  o_result_kind;
    logic [3:0]  o_slot_index;
    logic [15:0] o_active_mask;
    logic        o_is_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    multiplexed_timer_scheduler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_timer_index(i_timer_index),
        .i_period_ticks(i_period_ticks), .o_valid(o_valid),
        .o_result_kind(o_result_kind), .o_slot_index(o_slot_index),
        .o_active_mask(o_active_mask), .o_is_last(o_is_last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the scheduler state.
    logic [15:0] shadow_repeat;
    logic [31:0] shadow_now;
    logic [31:0] shadow_deadline [16];
    logic [31:0] shadow_period [16];
    logic [15:0] shadow_armed;
    logic [3:0]  shadow_order [16];
    int          shadow_count;

    t_timer_event pending_events[$];
    int  error_count;
    int  idle_cycles;
    int  send_gap_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] time_to_go(input logic [3:0] s);
        logic [31:0] r;
        r = shadow_deadline[s] - shadow_now;
        return r[31] ? 32'd0 : r;
    endfunction

    function automatic void order_insert(input logic [3:0] s);
        logic [31:0] mine;
        int pos;
        mine = time_to_go(s);
        pos = 0;
        while (pos < shadow_count && time_to_go(shadow_order[pos]) <= mine)
            pos++;
        for (int i = shadow_count; i > pos; i--)
            shadow_order[i] = shadow_order[i-1];
        shadow_order[pos] = s;
        shadow_count++;
    endfunction

    function automatic void order_remove(input logic [3:0] s);
        int pos;
        pos = 0;
        while (pos < shadow_count && shadow_order[pos] != s)
            pos++;
        if (pos >= shadow_count)
            return;
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_order[i] = shadow_order[i+1];
        shadow_count--;
    endfunction

    function automatic void push_event(input t_kind k, input logic [3:0] s,
                                       input logic l);
        t_timer_event ev;
        ev.kind = k;
        ev.slot = s;
        ev.mask = shadow_armed;
        ev.last = l;
        pending_events.push_back(ev);
    endfunction

    // Advance the shadow state for one request and queue the events it causes.
    function automatic void predict_request(input t_req rq, input logic [3:0] idx,
                                            input logic [30:0] per);
        int n;
        logic [3:0] s;
        n = 0;
        case (rq)
            REQ_START: begin
                if (per == '0) begin
                    push_event(KIND_REJECTED, idx, 1'b1);
                end else begin
                    if (!shadow_armed[idx]) begin
                        shadow_period[idx] = {1'b0, per};
                        shadow_deadline[idx] = shadow_now + {1'b0, per};
                        shadow_armed[idx] = 1'b1;
                        order_insert(idx);
                    end
                    push_event(KIND_ACCEPTED, idx, 1'b1);
                end
            end
            REQ_STOP: begin
                if (shadow_armed[idx]) begin
                    order_remove(idx);
                    shadow_armed[idx] = 1'b0;
                    if (shadow_count == 0)
                        shadow_now = '0;
                end
                push_event(KIND_ACCEPTED, idx, 1'b1);
            end
            REQ_TICK: begin
                shadow_now = shadow_now + 32'd1;
                while (shadow_count > 0 && n < 16) begin
                    s = shadow_order[0];
                    if (time_to_go(s) != 0)
                        break;
                    order_remove(s);
                    shadow_armed[s] = 1'b0;
                    if (shadow_repeat[s]) begin
                        shadow_deadline[s] = shadow_deadline[s] + shadow_period[s];
                        shadow_armed[s] = 1'b1;
                        order_insert(s);
                    end
                    push_event(KIND_EXPIRED, s, 1'b0);
                    n++;
                end
                if (shadow_count == 0)
                    shadow_now = '0;
                if (n == 0)
                    push_event(KIND_NO_EXPIRY, 4'd0, 1'b1);
                else
                    pending_events[$].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Compare every strobed result against the oldest expected event.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected result expected none actual kind=%0d slot=%0d",
                         $time, o_result_kind, o_slot_index);
                error_count++;
            end else begin
                t_timer_event ev;
                ev = pending_events.pop_front();
                if (o_result_kind !== ev.kind) begin
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, ev.kind, o_result_kind);
                    error_count++;
                end
                if (o_slot_index !== ev.slot) begin
                    $display("%0t: slot_index expected %0d actual %0d",
                             $time, ev.slot, o_slot_index);
                    error_count++;
                end
                if (o_active_mask !== ev.mask) begin
                    $display("%0t: active_mask expected %h actual %h",
                             $time, ev.mask, o_active_mask);
                    error_count++;
                end
                if (o_is_last !== ev.last) begin
                    $display("%0t: is_last expected %0d actual %0d",
                             $time, ev.last, o_is_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no request is taken, no result strobed and no register access made for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Send one request; hold start until the block takes it. Start drops only
    // while idling, so a request can follow the previous one with no gap.
    task automatic send_request(input t_req rq, input logic [3:0] idx,
                                input logic [30:0] per);
        while ($urandom_range(99, 0) < send_gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= rq;
        i_timer_index <= idx;
        i_period_ticks <= per;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_request(rq, idx, per);
        @(negedge i_clk);
    endtask

    // Wait for all events, then let the block settle before a register write.
    task automatic drain;
        start <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_repeat_mask(input logic [15:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_repeat = value;
    endtask

    // Mostly short periods so expiries and re-arms happen often.
    function automatic logic [30:0] pick_period;
        case ($urandom_range(19, 0))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(12, 1));
        endcase
    endfunction

    task automatic test_directed;
        // one-shot and repeating slots, extremes of every field
        send_request(REQ_TICK, 4'd0, '0);
        send_request(REQ_START, 4'd0, 31'd1);
        send_request(REQ_START, 4'd15, 31'd2);
        send_request(REQ_START, 4'd5, 31'd2);
        send_request(REQ_START, 4'd5, 31'd9);
        send_request(REQ_START, 4'd15, '0);
        send_request(REQ_START, 4'd10, 31'h7FFF_FFFF);
        send_request(REQ_START, 4'd7, 31'h5555_5555);
        send_request(REQ_START, 4'd8, 31'h2AAA_AAAA);
        send_request(REQ_NONE, 4'd3, 31'd4);
        send_request(REQ_TICK, 4'd9, '0);
        send_request(REQ_TICK, 4'd0, '0);
        send_request(REQ_TICK, 4'd0, '0);
        send_request(REQ_STOP, 4'd3, '0);
        send_request(REQ_STOP, 4'd10, '0);
        send_request(REQ_STOP, 4'd15, '0);
        send_request(REQ_STOP, 4'd7, '0);
        send_request(REQ_STOP, 4'd8, '0);
        send_request(REQ_TICK, 4'd0, '0);
        send_request(REQ_STOP, 4'd0, '0);
        send_request(REQ_STOP, 4'd5, '0);
    endtask

    task automatic test_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99, 0);
            if (r < 30)
                send_request(REQ_START, 4'($urandom), pick_period());
            else if (r < 40)
                send_request(REQ_STOP, 4'($urandom), 31'($urandom));
            else if (r < 97)
                send_request(REQ_TICK, 4'($urandom), 31'($urandom));
            else
                send_request(REQ_NONE, 4'($urandom), 31'($urandom));
        end
    endtask

    // Start all sixteen slots with equal periods so that those armed here expire on one tick.
    task automatic test_full_burst;
        for (int s = 0; s < 16; s++)
            send_request(REQ_START, 4'(s), 31'd3);
        repeat (4) send_request(REQ_TICK, 4'd0, '0);
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        send_gap_pct = 21;
        start = 1'b0;
        i_req_type = REQ_TICK;
        i_timer_index = '0;
        i_period_ticks = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        shadow_repeat = '0;
        shadow_now = '0;
        shadow_armed = '0;
        shadow_count = 0;
        for (int s = 0; s < 16; s++) begin
            shadow_deadline[s] = '0;
            shadow_period[s] = '0;
            shadow_order[s] = '0;
        end
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_repeat_mask(16'h0020);
        test_directed();
        write_repeat_mask(16'hFFFF);
        test_full_burst();
        test_random(130);

        send_gap_pct = 77;
        write_repeat_mask(16'h0000);
        test_full_burst();
        test_random(110);

        send_gap_pct = 0;
        write_repeat_mask(16'($urandom));
        test_random(130);

        drain();
        if (error_count == 0 && pending_events.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
